/* sv/assert_macros.svh */
// Assertion macros shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int CELL_DATA_W = 16;

   localparam logic [7:0] COLOR_RESET = 8'h0f;
   localparam logic [7:0] ATTR_PLAIN  = 8'h0f;
   localparam logic [7:0] ATTR_CURSOR = 8'hf0;

   localparam logic [7:0] KEY_BACKSPACE = 8'd8;
   localparam logic [7:0] KEY_NEWLINE   = 8'd10;
   localparam logic [7:0] KEY_RETURN    = 8'd13;
   localparam logic [7:0] KEY_ESCAPE    = 8'h1b;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OLD_RD,
      ST_OLD_WR,
      ST_CHAR_WR,
      ST_BS_RD,
      ST_BS_WR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FILL,
      ST_CUR_RD,
      ST_CUR_WR,
      ST_CELL_RD,
      ST_DONE
   } tcw_state_type;

endpackage

/* sv/tcw_cell_ram.sv */
// Single-port-write, single-port-read cell memory with registered read data.
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/text_console_writer.sv */
// Top level of the text console writer: sequencer, cursor and result register.
//
//   port group   role    handshake            contents
//   req_*        in      valid / stall        opcode, char_code, cell_index
//   rsp_*        out     valid / stall        cursor_index, read_char, read_attribute, scrolled
//   csr_*        config  write enable, data   text_color
//
// All cell traffic goes through one memory with one write and one registered read port,
// so an item is a short sequence of memory steps:
//   a read is one cell read; other bytes unmark the old cursor cell or write the character,
//   then read and mark the new cursor cell; backspace also blanks the stepped-back cell.
//   A scroll adds a row copy, then a blank bottom row; escape adds a blanking sweep.
// After reset all ROWS*COLUMNS cells (2000 by default) are swept to zero with req_stall high;
// csr writes are taken during the sweep.
// The result register lets the next item enter while a result waits on rsp_stall.
`include "assert_macros.svh"

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_index,
   output logic [7:0]  rsp_read_char,
   output logic [7:0]  rsp_read_attribute,
   output logic        rsp_scrolled,

   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int LAST_ROW   = CELL_COUNT - COLUMNS;   // first cell of the bottom row
   localparam int KEEP       = LAST_ROW;               // cells moved by a one-row scroll

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   tcw_state_type      state_ff, state_in;
   logic [CELL_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]   col_ff, col_in;       // cursor column, kept beside the position
   logic [CELL_W-1:0]  ptr_ff, ptr_in;       // sweep pointer for clear, copy and fill
   logic [7:0]         color_ff, color_in;

   logic               opcode_ff, opcode_in;
   logic [7:0]         char_ff, char_in;
   logic [10:0]        idx_ff, idx_in;
   logic               in_range_ff, in_range_in;
   logic               scroll_ff, scroll_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [10:0]        rsp_cursor_ff, rsp_cursor_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic [7:0]         rsp_attr_ff, rsp_attr_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   // ---------------------------------------------------------------------------
   // Memory port signals
   // ---------------------------------------------------------------------------
   logic                   mem_we;
   logic [CELL_W-1:0]      mem_waddr;
   logic [CELL_DATA_W-1:0] mem_wdata;
   logic                   mem_re;
   logic [CELL_W-1:0]      mem_raddr;
   logic [CELL_DATA_W-1:0] mem_rdata;

   tcw_cell_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (CELL_W),
      .DATA_W (CELL_DATA_W)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------------
   logic req_accept;
   logic out_free;
   logic load_out;
   logic stall_w;

   assign req_accept = req_valid && !stall_w;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // Finish in CUR_WR or DONE (reads) when the result register is free, else wait in DONE.
   assign load_out   = (state_ff == ST_CUR_WR || state_ff == ST_DONE) && out_free;

   // ---------------------------------------------------------------------------
   // Cursor step: new position, column and scroll flag for the byte in char_ff
   // ---------------------------------------------------------------------------
   logic [CELL_W-1:0] cur_nxt;
   logic [COL_W-1:0]  col_nxt;
   logic              scroll_nxt;
   logic [CELL_W-1:0] row_start;
   logic              last_row;
   logic              col_last;

   always_comb begin
      row_start  = cursor_ff - CELL_W'(col_ff);
      last_row   = cursor_ff >= CELL_W'(LAST_ROW);
      col_last   = col_ff == COL_W'(COLUMNS - 1);
      cur_nxt    = cursor_ff;
      col_nxt    = col_ff;
      scroll_nxt = 1'b0;
      case (char_ff)
         KEY_NEWLINE: begin
            col_nxt = '0;
            if (last_row) begin
               // Pass the bottom row: land on its start and scroll.
               cur_nxt    = CELL_W'(LAST_ROW);
               scroll_nxt = 1'b1;
            end else begin
               cur_nxt = row_start + CELL_W'(COLUMNS);
            end
         end
         KEY_RETURN: begin
            cur_nxt = row_start;
            col_nxt = '0;
         end
         KEY_BACKSPACE: begin
            // Hold at the home cell rather than wrap around.
            if (cursor_ff != '0) begin
               cur_nxt = cursor_ff - CELL_W'(1);
               col_nxt = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - COL_W'(1);
            end
         end
         KEY_ESCAPE: begin
            cur_nxt    = '0;
            col_nxt    = '0;
            scroll_nxt = 1'b1;
         end
         default: begin
            if (col_last) begin
               col_nxt = '0;
               if (last_row) begin
                  cur_nxt    = CELL_W'(LAST_ROW);
                  scroll_nxt = 1'b1;
               end else begin
                  cur_nxt = cursor_ff + CELL_W'(1);
               end
            end else begin
               cur_nxt = cursor_ff + CELL_W'(1);
               col_nxt = col_ff + COL_W'(1);
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == CELL_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OP_READ) begin
                  state_in = ST_CELL_RD;
               end else begin
                  case (req_char_code) inside
                     KEY_NEWLINE, KEY_RETURN, KEY_BACKSPACE, KEY_ESCAPE: state_in = ST_OLD_RD;
                     default: state_in = ST_CHAR_WR;
                  endcase
               end
            end
         end
         ST_OLD_RD: state_in = ST_OLD_WR;
         ST_OLD_WR: begin
            case (char_ff)
               KEY_BACKSPACE: state_in = ST_BS_RD;
               KEY_ESCAPE:    state_in = ST_FILL;
               default:       state_in = scroll_nxt ? ST_COPY_RD : ST_CUR_RD;
            endcase
         end
         ST_CHAR_WR: state_in = scroll_nxt ? ST_COPY_RD : ST_CUR_RD;
         ST_BS_RD:   state_in = ST_BS_WR;
         ST_BS_WR:   state_in = ST_CUR_RD;
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            state_in = (ptr_ff == CELL_W'(KEEP - 1)) ? ST_FILL : ST_COPY_RD;
         end
         ST_FILL: begin
            if (ptr_ff == CELL_W'(CELL_COUNT - 1)) begin
               state_in = ST_CUR_RD;
            end
         end
         ST_CUR_RD:  state_in = ST_CUR_WR;
         ST_CUR_WR:  state_in = out_free ? ST_IDLE : ST_DONE;
         ST_CELL_RD: state_in = ST_DONE;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer: memory controls and input stall
   // ---------------------------------------------------------------------------
   always_comb begin
      stall_w   = state_ff != ST_IDLE;
      mem_we    = 1'b0;
      mem_waddr = cursor_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = cursor_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // Power-up sweep: every cell to zero.
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
         end
         ST_OLD_RD, ST_BS_RD, ST_CUR_RD: begin
            mem_re = 1'b1;
         end
         ST_OLD_WR: begin
            // Drop the cursor mark at the old position.
            mem_we    = 1'b1;
            mem_wdata = {ATTR_PLAIN, mem_rdata[7:0]};
         end
         ST_CHAR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {color_ff, char_ff};
         end
         ST_BS_WR: begin
            // cursor_ff already holds the stepped-back cell.
            mem_we    = 1'b1;
            mem_wdata = {mem_rdata[15:8], 8'h00};
         end
         ST_COPY_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff + CELL_W'(COLUMNS);
         end
         ST_COPY_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = mem_rdata;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = {color_ff, 8'h00};
         end
         ST_CUR_WR: begin
            // Mark the new cursor cell.
            mem_we    = 1'b1;
            mem_wdata = {ATTR_CURSOR, mem_rdata[7:0]};
         end
         ST_CELL_RD: begin
            mem_re    = in_range_ff;
            mem_raddr = CELL_W'(idx_ff);
         end
         ST_IDLE, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------------
   always_comb begin
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      ptr_in      = ptr_ff;
      color_in    = csr_wr_en ? csr_wr_data : color_ff;
      opcode_in   = opcode_ff;
      char_in     = char_ff;
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      scroll_in   = scroll_ff;

      if (req_accept) begin
         opcode_in   = req_opcode;
         char_in     = req_char_code;
         idx_in      = req_cell_index;
         in_range_in = 32'(req_cell_index) < 32'(CELL_COUNT);
         scroll_in   = 1'b0;
      end

      case (state_ff)
         ST_OLD_WR, ST_CHAR_WR: begin
            // Advance the cursor; start the row copy or the escape fill sweep at cell zero.
            cursor_in = cur_nxt;
            col_in    = col_nxt;
            scroll_in = scroll_nxt;
            ptr_in    = '0;
         end
         ST_COPY_WR: begin
            ptr_in = (ptr_ff == CELL_W'(KEEP - 1)) ? CELL_W'(KEEP) : ptr_ff + CELL_W'(1);
         end
         ST_CLEAR, ST_FILL: begin
            ptr_in = ptr_ff + CELL_W'(1);
         end
         default: begin
         end
      endcase

      rsp_valid_in    = load_out || (rsp_valid_ff && rsp_stall);
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      if (load_out) begin
         rsp_cursor_in   = 11'(cursor_ff);
         rsp_scrolled_in = scroll_ff;
         if (opcode_ff == OP_READ && in_range_ff) begin
            rsp_char_in = mem_rdata[7:0];
            rsp_attr_in = mem_rdata[15:8];
         end else begin
            rsp_char_in = '0;
            rsp_attr_in = '0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff       <= opcode_in;
      char_ff         <= char_in;
      idx_ff          <= idx_in;
      in_range_ff     <= in_range_in;
      scroll_ff       <= scroll_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign req_stall          = stall_w;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_index   = rsp_cursor_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_read_attribute = rsp_attr_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   logic cursor_ok;
   logic read_accept;
   logic copy_ok;

   assign cursor_ok   = (32'(cursor_ff) < 32'(CELL_COUNT)) && (32'(col_ff) < 32'(COLUMNS));
   assign read_accept = req_accept && req_opcode == OP_READ;
   assign copy_ok     = state_ff != ST_COPY_WR || 32'(ptr_ff) < 32'(KEEP);

   `ASSERT_ALWAYS(a_cursor_in_store, clock, reset, cursor_ok, "cursor outside the store")
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(load_out), "stray result")
   `ASSERT_NEXT(a_read_path, clock, reset, read_accept, state_ff == ST_CELL_RD, "read not started")
   `ASSERT_ALWAYS(a_copy_in_range, clock, reset, copy_ok, "scroll copy ran past the kept rows")

endmodule
